@@ hdl/tlrt_pkg.sv @@
// shared types, character codes and decode function for the text line ring terminal
package tlrt_pkg;

  localparam int NUM_LINES_DEF  = 5;
  localparam int LINE_WIDTH_DEF = 80;

  localparam logic [7:0] CH_BS    = 8'd8;
  localparam logic [7:0] CH_TAB   = 8'd9;
  localparam logic [7:0] CH_NL    = 8'd10;
  localparam logic [7:0] CH_FF    = 8'd12;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_SPACE = 8'o40;
  localparam logic [7:0] PRINT_LO = 8'o40;
  localparam logic [7:0] PRINT_HI = 8'o176;
  localparam int         TAB_BITS = 2;

  localparam logic OP_PUT  = 1'b0;
  localparam logic OP_READ = 1'b1;

  typedef struct packed {
    logic       op;
    logic [7:0] char_code;
    logic [2:0] read_line;
    logic [6:0] read_col;
  } req_t;

  typedef struct packed {
    logic [7:0] cell_char;
    logic [6:0] cursor_col;
    logic [2:0] newest_line;
  } rsp_t;

  typedef enum logic [2:0] {
    KIND_NL,
    KIND_CR,
    KIND_BS,
    KIND_FF,
    KIND_TAB,
    KIND_PRINT,
    KIND_OTHER
  } char_kind_t;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_CLEAR,
    DP_NEWLINE,
    DP_CR,
    DP_BS,
    DP_WRAP,
    DP_WR_CHAR,
    DP_WR_TERM,
    DP_RD_ADDR,
    DP_RD_OUT
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   load_item;
  } dp_cmd_t;

  typedef struct packed {
    char_kind_t kind;
    logic       is_read;
    logic       cursor_zero;
    logic       at_width;
    logic       aligned;
    logic       clr_last;
    logic       out_busy;
  } dp_status_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DECODE,
    ST_FF,
    ST_CHAR,
    ST_TERM,
    ST_RD_ADDR,
    ST_RD_OUT
  } ctrl_state_t;

  function automatic char_kind_t char_kind(input logic [7:0] code);
    char_kind_t k;
    unique case (code)
      CH_NL:   k = KIND_NL;
      CH_CR:   k = KIND_CR;
      CH_BS:   k = KIND_BS;
      CH_FF:   k = KIND_FF;
      CH_TAB:  k = KIND_TAB;
      default: k = (code >= PRINT_LO && code <= PRINT_HI) ? KIND_PRINT : KIND_OTHER;
    endcase
    return k;
  endfunction

endpackage

@@ hdl/text_line_ring_terminal_top.sv @@
// top level of the text line ring terminal: controller plus datapath
// After reset the block runs a clearing pass over all NUM_LINES*(LINE_WIDTH+1)
// store cells (405 at the defaults), writing one store cell per cycle, and holds
// req_stall high until it finishes. Each item then uses the single-port store:
// the idle state takes the transfer and the decode state decodes it; a read then
// passes the address state (registered read data) and the output state, waiting
// there only if the previous result is still stalled; newline, carriage return and
// backspace (if not at column zero) take one store write; a printable character
// takes two writes plus a wrap step when it wraps; a tab does so per space for up
// to four spaces; form feed takes NUM_LINES writes. A result waits in its own
// output register, so the next request transfer can be taken while it is stalled.
module text_line_ring_terminal_top #(
  parameter int NUM_LINES  = tlrt_pkg::NUM_LINES_DEF,
  parameter int LINE_WIDTH = tlrt_pkg::LINE_WIDTH_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  tlrt_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output tlrt_pkg::rsp_t rsp
);
  import tlrt_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  tlrt_ctrl #(
    .NUM_LINES(NUM_LINES)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .status    (status),
    .cmd       (cmd)
  );

  tlrt_dp #(
    .NUM_LINES (NUM_LINES),
    .LINE_WIDTH(LINE_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd       (cmd),
    .status    (status),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

endmodule

@@ hdl/tlrt_ctrl.sv @@
// controller state machine sequencing store writes, reads and the clearing pass
module tlrt_ctrl #(
  parameter int NUM_LINES = tlrt_pkg::NUM_LINES_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_stall,
  input  tlrt_pkg::dp_status_t status,
  output tlrt_pkg::dp_cmd_t    cmd
);
  import tlrt_pkg::*;

  localparam int LW = $clog2(NUM_LINES);

  ctrl_state_t   state, state_next;
  logic [LW-1:0] ff_count, ff_count_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      ff_count <= '0;
    end else begin
      state    <= state_next;
      ff_count <= ff_count_next;
    end
  end

  always_comb begin
    state_next     = state;
    ff_count_next  = ff_count;
    cmd.op         = DP_NOP;
    cmd.load_item  = 1'b0;
    req_stall      = 1'b1;
    unique case (state)
      ST_CLEAR: begin
        cmd.op = DP_CLEAR;
        if (status.clr_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        req_stall = 1'b0;
        if (req_valid) begin
          cmd.load_item = 1'b1;
          state_next    = ST_DECODE;
        end
      end
      ST_DECODE: begin
        state_next = ST_IDLE;
        if (status.is_read) begin
          state_next = ST_RD_ADDR;
        end else begin
          unique case (status.kind)
            KIND_NL: cmd.op = DP_NEWLINE;
            KIND_CR: cmd.op = DP_CR;
            KIND_BS: if (!status.cursor_zero) cmd.op = DP_BS;
            KIND_FF: begin
              ff_count_next = '0;
              state_next    = ST_FF;
            end
            KIND_TAB, KIND_PRINT: state_next = ST_CHAR;
            default: state_next = ST_IDLE;
          endcase
        end
      end
      ST_FF: begin
        cmd.op = DP_NEWLINE;
        if (ff_count == LW'(NUM_LINES - 1)) begin
          state_next = ST_IDLE;
        end else begin
          ff_count_next = ff_count + 1'b1;
        end
      end
      ST_CHAR: begin
        if (status.at_width) begin
          cmd.op = DP_WRAP;
        end else begin
          cmd.op     = DP_WR_CHAR;
          state_next = ST_TERM;
        end
      end
      ST_TERM: begin
        cmd.op = DP_WR_TERM;
        if (status.kind == KIND_TAB && !status.aligned) begin
          state_next = ST_CHAR;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_RD_ADDR: begin
        cmd.op     = DP_RD_ADDR;
        state_next = ST_RD_OUT;
      end
      ST_RD_OUT: begin
        if (!status.out_busy) begin
          cmd.op     = DP_RD_OUT;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

@@ hdl/tlrt_dp.sv @@
// datapath: line store memory, line and cursor registers, item and result registers
module tlrt_dp #(
  parameter int NUM_LINES  = tlrt_pkg::NUM_LINES_DEF,
  parameter int LINE_WIDTH = tlrt_pkg::LINE_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  tlrt_pkg::req_t       req,
  input  tlrt_pkg::dp_cmd_t    cmd,
  output tlrt_pkg::dp_status_t status,
  output logic                 rsp_valid,
  input  logic                 rsp_stall,
  output tlrt_pkg::rsp_t       rsp
);
  import tlrt_pkg::*;

  localparam int ROW_CELLS   = LINE_WIDTH + 1;
  localparam int STORE_CELLS = NUM_LINES * ROW_CELLS;
  localparam int LW          = $clog2(NUM_LINES);
  localparam int CW          = $clog2(LINE_WIDTH + 1);
  localparam int AW          = $clog2(STORE_CELLS);
  localparam int COLW        = (CW > 7) ? CW : 7;
  localparam int SW          = ((LW > 3) ? LW : 3) + 2;
  localparam logic [AW-1:0] ROW_A = AW'(ROW_CELLS);

  logic [7:0]    mem [STORE_CELLS];
  req_t          item;
  logic [LW-1:0] line, line_next;
  logic [CW-1:0] cursor, cursor_next;
  logic [AW-1:0] clr_addr;
  logic [7:0]    rd_data;
  logic          rd_ok;

  logic [LW-1:0]   nl_line;
  logic [LW-1:0]   addr_line;
  logic [COLW-1:0] addr_col;
  logic [AW-1:0]   addr;
  logic            wr_en;
  logic [7:0]      wr_data;
  logic [SW-1:0]   phys_sum;
  logic [SW-1:0]   phys_wrap;
  logic            rd_in_range;
  logic [CW+6:0]   cursor_ext;
  logic [LW+2:0]   line_ext;

  assign nl_line   = (line == LW'(NUM_LINES - 1)) ? '0 : line + 1'b1;
  assign phys_sum  = SW'(line) + SW'(1) + SW'(item.read_line);
  assign phys_wrap = (phys_sum >= SW'(NUM_LINES)) ? phys_sum - SW'(NUM_LINES) : phys_sum;
  assign rd_in_range = (int'(item.read_line) < NUM_LINES) &&
                       (int'(item.read_col) <= LINE_WIDTH);

  always_comb begin
    line_next   = line;
    cursor_next = cursor;
    wr_en       = 1'b0;
    wr_data     = 8'd0;
    addr_line   = line;
    addr_col    = COLW'(cursor);
    unique case (cmd.op)
      DP_NEWLINE: begin
        line_next   = nl_line;
        cursor_next = '0;
        addr_line   = nl_line;
        addr_col    = '0;
        wr_en       = 1'b1;
      end
      DP_CR: begin
        cursor_next = '0;
        addr_col    = '0;
        wr_en       = 1'b1;
      end
      DP_BS: begin
        if (cursor != '0) begin
          cursor_next = cursor - 1'b1;
          addr_col    = COLW'(cursor - 1'b1);
          wr_en       = 1'b1;
        end
      end
      DP_WRAP: begin
        line_next   = nl_line;
        cursor_next = '0;
      end
      DP_WR_CHAR: begin
        cursor_next = cursor + 1'b1;
        wr_en       = 1'b1;
        wr_data     = (char_kind(item.char_code) == KIND_TAB) ? CH_SPACE : item.char_code;
      end
      DP_WR_TERM: begin
        wr_en = 1'b1;
      end
      DP_RD_ADDR: begin
        addr_line = phys_wrap[LW-1:0];
        addr_col  = COLW'(item.read_col);
      end
      default: begin
      end
    endcase
  end

  assign addr = AW'(addr_line) * ROW_A + AW'(addr_col);

  always_ff @(posedge clk) begin
    if (cmd.op == DP_CLEAR) begin
      mem[clr_addr] <= 8'd0;
    end else if (wr_en) begin
      mem[addr] <= wr_data;
    end
    if (cmd.op == DP_RD_ADDR) begin
      rd_data <= mem[addr];
      rd_ok   <= rd_in_range;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line      <= '0;
      cursor    <= '0;
      clr_addr  <= '0;
      rsp_valid <= 1'b0;
    end else begin
      line   <= line_next;
      cursor <= cursor_next;
      if (cmd.op == DP_CLEAR) clr_addr <= clr_addr + 1'b1;
      if (cmd.op == DP_RD_OUT) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  assign cursor_ext = {7'd0, cursor};
  assign line_ext   = {3'd0, line};

  always_ff @(posedge clk) begin
    if (cmd.load_item) item <= req;
    if (cmd.op == DP_RD_OUT) begin
      rsp.cell_char   <= rd_ok ? rd_data : 8'd0;
      rsp.cursor_col  <= cursor_ext[6:0];
      rsp.newest_line <= line_ext[2:0];
    end
  end

  always_comb begin
    status.kind        = char_kind(item.char_code);
    status.is_read     = (item.op == OP_READ);
    status.cursor_zero = (cursor == '0);
    status.at_width    = (int'(cursor) >= LINE_WIDTH);
    status.aligned     = (cursor[TAB_BITS-1:0] == '0);
    status.clr_last    = (clr_addr == AW'(STORE_CELLS - 1));
    status.out_busy    = rsp_valid && rsp_stall;
  end

  a_cursor_range: assert property (@(posedge clk) disable iff (rst)
    int'(cursor) <= LINE_WIDTH)
    else $error("cursor beyond line width");

  a_line_range: assert property (@(posedge clk) disable iff (rst)
    int'(line) < NUM_LINES)
    else $error("current line outside ring");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.op == DP_RD_OUT |-> !(rsp_valid && rsp_stall))
    else $error("result loaded over a waiting result");

  a_rsp_kept: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid)
    else $error("waiting result dropped");

endmodule

@@ tb/sv/tb_top.sv @@
// self-checking testbench for the text line ring terminal: stimulus, line store shadow, checks
module tb_top;
  import tlrt_pkg::*;

  localparam int NLINES     = NUM_LINES_DEF;
  localparam int LWIDTH     = LINE_WIDTH_DEF;
  localparam int ITEM_GOAL  = 900;
  localparam int IDLE_LIMIT = 6000;
  localparam int MAX_REPORT = 10;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;

  text_line_ring_terminal_top u_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  wire req_fire = req_valid && !req_stall;
  wire rsp_fire = rsp_valid && !rsp_stall;

  req_t pending_items[$];
  rsp_t expected_cells[$];
  int   n_errors   = 0;
  int   n_accepted = 0;
  int   n_cycles   = 0;
  int   idle_count = 0;
  int   req_gap    = 0;
  int   rsp_hold   = 0;

  // shadow of the line store and the cursor
  logic [7:0] shadow_text [NLINES][LWIDTH+1];
  logic [2:0] cur_line = '0;
  logic [6:0] cur_col  = '0;

  initial begin
    for (int l = 0; l < NLINES; l++)
      for (int c = 0; c <= LWIDTH; c++)
        shadow_text[l][c] = 8'h00;
  end

  function automatic void text_newline();
    cur_line = (cur_line == NLINES - 1) ? 3'd0 : cur_line + 3'd1;
    cur_col = '0;
    shadow_text[cur_line][0] = 8'h00;
  endfunction

  function automatic void text_print(logic [7:0] code);
    if (cur_col >= LWIDTH) text_newline();
    shadow_text[cur_line][cur_col] = code;
    cur_col = cur_col + 7'd1;
    shadow_text[cur_line][cur_col] = 8'h00;
  endfunction

  function automatic void text_put(logic [7:0] code);
    case (code)
      CH_NL: text_newline();
      CH_CR: begin
        cur_col = '0;
        shadow_text[cur_line][0] = 8'h00;
      end
      CH_BS: begin
        if (cur_col > 0) begin
          cur_col = cur_col - 7'd1;
          shadow_text[cur_line][cur_col] = 8'h00;
        end
      end
      CH_FF: begin
        for (int i = 0; i < NLINES; i++) text_newline();
      end
      CH_TAB: begin
        do text_print(CH_SPACE); while (cur_col[TAB_BITS-1:0] != '0);
      end
      default: begin
        if (code >= PRINT_LO && code <= PRINT_HI) text_print(code);
      end
    endcase
  endfunction

  function automatic rsp_t text_read(logic [2:0] line, logic [6:0] col);
    rsp_t r;
    int   phys;
    r.cell_char = 8'h00;
    if (line < NLINES && col <= LWIDTH) begin
      phys = (int'(cur_line) + 1 + int'(line)) % NLINES;
      r.cell_char = shadow_text[phys][col];
    end
    r.cursor_col  = cur_col;
    r.newest_line = cur_line;
    return r;
  endfunction

  function automatic int pick_gap(bit quiet);
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // request driver, with the shadow updated on each transfer
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (!(req_valid && req_stall)) begin
      if (req_fire) begin
        n_accepted++;
        if (req.op == OP_READ) expected_cells.push_back(text_read(req.read_line, req.read_col));
        else text_put(req.char_code);
      end
      if (req_gap > 0) begin
        req_gap--;
        req_valid <= 1'b0;
      end else if (pending_items.size() > 0) begin
        req_valid <= 1'b1;
        req <= pending_items.pop_front();
        req_gap = pick_gap((n_accepted % 256) < 48);
      end else begin
        req_valid <= 1'b0;
      end
    end
  end

  // response stall pattern
  always @(posedge clk) begin
    n_cycles++;
    if (rst) begin
      rsp_stall <= 1'b0;
    end else if (rsp_hold > 0) begin
      rsp_hold--;
      rsp_stall <= 1'b1;
    end else begin
      rsp_stall <= 1'b0;
      rsp_hold = pick_gap((n_cycles % 2000) < 300);
    end
  end

  task automatic report_field(string name, int exp_v, int got_v);
    if (exp_v != got_v) begin
      n_errors++;
      if (n_errors <= MAX_REPORT)
        $display("mismatch %s: expected %0d got %0d", name, exp_v, got_v);
    end
  endtask

  // response monitor
  always @(posedge clk) begin
    rsp_t exp_r;
    if (!rst && rsp_fire) begin
      if (expected_cells.size() == 0) begin
        n_errors++;
        if (n_errors <= MAX_REPORT)
          $display("unexpected result: cell %0d cursor %0d line %0d",
                   rsp.cell_char, rsp.cursor_col, rsp.newest_line);
      end else begin
        exp_r = expected_cells.pop_front();
        report_field("cell_char", exp_r.cell_char, rsp.cell_char);
        report_field("cursor_col", exp_r.cursor_col, rsp.cursor_col);
        report_field("newest_line", exp_r.newest_line, rsp.newest_line);
      end
    end
  end

  always @(posedge clk) begin
    if (req_fire || rsp_fire) idle_count = 0;
    else idle_count++;
    if (idle_count >= IDLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic add_put(logic [7:0] code);
    req_t it;
    it.op        = OP_PUT;
    it.char_code = code;
    it.read_line = 3'($urandom_range(0, 7));
    it.read_col  = 7'($urandom_range(0, 127));
    pending_items.push_back(it);
  endtask

  task automatic add_read(logic [2:0] line, logic [6:0] col);
    req_t it;
    it.op        = OP_READ;
    it.char_code = 8'($urandom_range(0, 255));
    it.read_line = line;
    it.read_col  = col;
    pending_items.push_back(it);
  endtask

  function automatic logic [7:0] rand_printable();
    return 8'($urandom_range(PRINT_LO, PRINT_HI));
  endfunction

  initial begin
    int n_items;
    int r;
    int run;

    // directed part
    add_read(3'd0, 7'd0);
    add_read(3'd7, 7'd127);
    add_read(3'd4, 7'd80);
    add_put(8'h41);
    add_put(PRINT_HI);
    add_put(PRINT_LO);
    add_put(8'h1f);
    add_put(8'h7f);
    add_put(8'h80);
    add_put(8'hff);
    add_put(8'h00);
    add_read(3'd4, 7'd0);
    add_read(3'd4, 7'd3);
    add_put(CH_BS);
    add_read(3'd4, 7'd2);
    add_put(CH_TAB);
    add_read(3'd4, 7'd3);
    add_put(CH_CR);
    add_put(CH_BS);
    add_put(CH_NL);
    add_put(8'h7a);
    add_read(3'd3, 7'd0);
    add_put(CH_FF);
    add_read(3'd4, 7'd0);
    add_read(3'd5, 7'd0);
    add_read(3'd0, 7'd81);

    // random part, mostly text runs with control codes and reads mixed in
    n_items = 0;
    while (n_items < ITEM_GOAL) begin
      r = $urandom_range(0, 99);
      if (r < 45) begin
        run = ($urandom_range(0, 9) == 0) ? $urandom_range(70, 100) : $urandom_range(1, 12);
        for (int i = 0; i < run; i++) add_put(rand_printable());
        n_items += run;
      end else if (r < 53) begin
        add_put(CH_NL);
        n_items++;
      end else if (r < 57) begin
        add_put(CH_CR);
        n_items++;
      end else if (r < 62) begin
        run = $urandom_range(1, 4);
        for (int i = 0; i < run; i++) add_put(CH_BS);
        n_items += run;
      end else if (r < 66) begin
        add_put(CH_TAB);
        n_items++;
      end else if (r < 67) begin
        add_put(CH_FF);
        n_items++;
      end else if (r < 71) begin
        add_put(8'($urandom_range(0, 255)));
        n_items++;
      end else if (r < 94) begin
        add_read(3'($urandom_range(0, 4)), 7'($urandom_range(0, 80)));
        n_items++;
      end else begin
        add_read(3'($urandom_range(0, 7)), 7'($urandom_range(0, 127)));
        n_items++;
      end
    end

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    while (pending_items.size() > 0 || req_valid || expected_cells.size() > 0)
      @(posedge clk);
    repeat (60) @(posedge clk);

    if (n_errors == 0 && expected_cells.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
